FILE: rtl/core/sha_pkg.sv
// Shared types, constants and the rotate helper for the SHA-256 stream hasher.
package sha_pkg;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_SLOT = 6'd56;

    localparam logic [31:0] INIT_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // commands from controller to datapath
    typedef struct packed {
        logic       load_byte;   // write s byte at fill, bump length
        logic       pad_write;   // write pad/zero/length byte at pad_addr
        logic [5:0] pad_addr;
        logic [7:0] pad_data;
        logic       comp_start;  // load working vars, round 0 next
        logic       comp_round;  // perform one round
        logic [5:0] round_idx;
        logic       comp_fold;   // chain += working vars
        logic       msg_clear;   // back to initial chain, zero length
        logic [2:0] out_sel;
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0]  fill_pos;
        logic [63:0] bit_len;
    } sha_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

endpackage

FILE: rtl/core/sha_datapath.sv
// Datapath: block buffer, message schedule window, working and chaining words.
module sha_datapath
    import sha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  sha_cmd_t    cmd,
    input  logic [7:0]  in_byte,
    output sha_stat_t   stat,
    output logic [31:0] out_word
);

    // block held as 16 big-endian words, byte lane 3 is the first byte
    logic [3:0][7:0] buf_reg [16];
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] chain_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;

    logic [31:0] w_cur, w_new, s0, s1, t1, t2, e, a;
    logic [31:0] bw [16];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            bw[i] = buf_reg[i];
        end
        w_cur = w_reg[0];
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        e = v_reg[4];
        a = v_reg[0];
        t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
           + ((e & v_reg[5]) ^ (~e & v_reg[6])) + ROUND_K[cmd.round_idx] + w_cur;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            buf_reg[fill_reg[5:2]][~fill_reg[1:0]] <= in_byte;
        end else if (cmd.pad_write) begin
            buf_reg[cmd.pad_addr[5:2]][~cmd.pad_addr[1:0]] <= cmd.pad_data;
        end
        if (cmd.comp_start) begin
            for (int i = 0; i < 16; i++) w_reg[i] <= bw[i];
            for (int i = 0; i < 8; i++) v_reg[i] <= chain_reg[i];
        end else if (cmd.comp_round) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            for (int i = 1; i < 8; i++) v_reg[i] <= v_reg[i-1];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.msg_clear) begin
            for (int i = 0; i < 8; i++) chain_reg[i] <= INIT_WORDS[i];
            fill_reg <= '0;
            len_reg  <= '0;
        end else begin
            if (cmd.load_byte) begin
                fill_reg <= fill_reg + 6'd1;
                len_reg  <= len_reg + 64'd8;
            end
            if (cmd.comp_fold) begin
                for (int i = 0; i < 8; i++) chain_reg[i] <= chain_reg[i] + v_reg[i];
            end
        end
    end

    assign stat.fill_pos = fill_reg;
    assign stat.bit_len  = len_reg;
    assign out_word      = chain_reg[cmd.out_sel];

endmodule

FILE: rtl/core/sha_ctrl.sv
// Controller: input handshake, padding sequence, round count, digest output.
module sha_ctrl
    import sha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_byte_present,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_word_index,
    output logic        m_last_word,
    input  sha_stat_t   stat,
    output sha_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PAD, ST_START, ST_ROUND, ST_FOLD, ST_OUT
    } state_t;

    state_t      state_reg;
    logic [5:0]  cnt_reg;      // pad address or round number
    logic        fin_reg;      // finishing a message
    logic        len_reg;      // this pad pass writes length
    logic [2:0]  idx_reg;
    logic        s_acc;
    logic [5:0]  pad_start;    // fill position once the end word's byte is in

    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign m_valid = (state_reg == ST_OUT);
    assign m_word_index = idx_reg;
    assign m_last_word  = (idx_reg == 3'd7);
    assign pad_start    = stat.fill_pos + {5'd0, s_byte_present};

    logic [5:0] len_off;
    assign len_off = cnt_reg - LEN_SLOT;

    always_comb begin
        cmd = '0;
        cmd.round_idx = cnt_reg;
        cmd.pad_addr  = cnt_reg;
        cmd.out_sel   = idx_reg;
        unique case (state_reg)
            ST_IDLE:  cmd.load_byte = s_acc && s_byte_present;
            ST_PAD: begin
                cmd.pad_write = 1'b1;
                if (len_reg && cnt_reg >= LEN_SLOT) begin
                    cmd.pad_data = stat.bit_len[8*(7-len_off[2:0]) +: 8];
                end else if (cnt_reg == stat.fill_pos) begin
                    cmd.pad_data = PAD_BYTE;
                end else begin
                    cmd.pad_data = 8'h00;
                end
            end
            ST_START: cmd.comp_start = 1'b1;
            ST_ROUND: cmd.comp_round = 1'b1;
            ST_FOLD:  cmd.comp_fold  = 1'b1;
            ST_OUT:   cmd.msg_clear  = m_ready && (idx_reg == 3'd7);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            fin_reg <= 1'b0;
            len_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (s_acc) begin
                    fin_reg <= s_end_of_message;
                    if (s_byte_present && stat.fill_pos == 6'd63) begin
                        state_reg <= ST_START;
                        len_reg <= 1'b0;
                    end else if (s_end_of_message) begin
                        state_reg <= ST_PAD;
                        cnt_reg <= pad_start;
                        // set when the length fits in this block; late fill needs a second block
                        len_reg <= (pad_start < LEN_SLOT);
                    end
                end
                ST_PAD: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        state_reg <= ST_START;
                    end
                end
                ST_START: begin
                    state_reg <= ST_ROUND;
                    cnt_reg <= '0;
                end
                ST_ROUND: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) state_reg <= ST_FOLD;
                end
                ST_FOLD: begin
                    cnt_reg <= '0;
                    if (!fin_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (!len_reg) begin
                        // a full block came in with the end item, or late fill
                        state_reg <= ST_PAD;
                        len_reg <= 1'b1;
                    end else begin
                        state_reg <= ST_OUT;
                        idx_reg <= '0;
                    end
                end
                ST_OUT: if (m_ready) begin
                    idx_reg <= idx_reg + 3'd1;
                    if (idx_reg == 3'd7) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken during output");
    a_out_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_word)
        |=> (m_valid && m_word_index == $past(m_word_index) + 3'd1))
        else $error("digest word order broken");
    a_round_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_START) |=> (state_reg == ST_ROUND && cnt_reg == 6'd0))
        else $error("round count not restarted");

endmodule

FILE: rtl/core/sha256_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_valid/s_ready   | s_msg_byte[8], s_byte_present, s_end_of_message
//  m_      | out | m_valid/m_ready   | m_digest_word[32], m_word_index[3], m_last_word
//
// A byte word is taken while idle; a word that fills the block starts a compression
// (load, 64 rounds on the single round unit, fold). The end word runs a padding sweep
// of the rest of the block, one byte a cycle, then compression; late fill adds a second
// sweep and compression. Eight digest words follow, one per accepted output handshake.
// Reset is synchronous, active low; s_ready is low while a block is padded or compressed
// and, after an end word, until the last digest word is taken; a stalled m_ready holds
// the current digest word.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_msg_byte,
    input  logic        s_byte_present,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    sha_cmd_t  cmd;
    sha_stat_t stat;

    sha_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_byte_present, .s_end_of_message,
        .m_valid, .m_ready, .m_word_index, .m_last_word, .stat, .cmd
    );

    sha_datapath u_dp (
        .aclk, .aresetn, .cmd, .in_byte(s_msg_byte), .stat, .out_word(m_digest_word)
    );

endmodule
